/* src/dfpc_pkg.sv */
// shared types and constants for the depth frame prequant and centroid block
// no dependencies; used by dfpc_div and the top level
`default_nettype none

package dfpc_pkg;

  localparam int GRID      = 8;
  localparam int IDX_W     = $clog2(GRID);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int ENERGY_W  = 12;
  localparam int SUM_W     = ENERGY_W + IDX_W;
  localparam int WSUM_W    = SUM_W + IDX_W;
  localparam int DEN_W     = SUM_W + IDX_W;
  localparam int PROD_W    = 48;

  // shared divider: wide enough for the centroid numerator and the norm denominator
  localparam int DIV_NUM_W = WSUM_W + 17;
  localparam int DIV_DEN_W = (DEN_W > 16) ? DEN_W : 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [15:0] CENTROID_DEFAULT   = 16'h8000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_CLAMP_LIMIT     = 2'd0,
    CFG_QUANT_GAIN      = 2'd1,
    CFG_ZERO_POINT      = 2'd2,
    CFG_SCORE_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FRAME = 1'b1
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] sample;
    logic [15:0] score;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [15:0]       norm;
    logic signed [7:0] quantized;
    logic [15:0]       centroid;
    logic              detected;
  } out_item_t;

endpackage

`default_nettype wire

/* src/dfpc_div.sv */
// restoring divider, one quotient bit per cycle, shared by norm and centroid
// depends on dfpc_pkg for operand widths
`default_nettype none

module dfpc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [dfpc_pkg::DIV_NUM_W-1:0]  num,
  input  logic [dfpc_pkg::DIV_DEN_W-1:0]  den,
  output logic                            done,
  output logic [dfpc_pkg::DIV_NUM_W-1:0]  quot
);
  import dfpc_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] den_r;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // numerator bits shift out of the top of quo_r while quotient bits shift in
  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

/* src/depth_frame_prequant_and_centroid_top.sv */
// top level of the depth frame prequant and centroid block
// depends on dfpc_pkg and dfpc_div
`default_nettype none

// Takes one item at a time (in_stall is high while an item is at work).
// A load item writes the background table in the cycle it is accepted.
// From acceptance to the next possible acceptance, a pixel item passes through
// S_PIX, S_QUANT, S_DIVW and S_DONE. A finish item passes through S_SUM, S_DEN,
// S_DIVW when a centroid is computed, and S_DONE. Their length is set by the
// shared one-bit-per-cycle divider, and for a finish item also by the walk
// over the column sums, one column a cycle.
// A finished result sits in an output register, so the next item is accepted
// while it waits to be taken. A new result waits only while the previous one
// is still held there. The background table has no reset: load every entry
// before sending pixels.
module depth_frame_prequant_and_centroid_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dfpc_pkg::in_item_t  in_item,
  output logic                out_vld,
  input  logic                out_stall,
  output dfpc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  dfpc_pkg::cfg_reg_t  cfg_index,
  input  logic [31:0]         cfg_data
);
  import dfpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX,
    S_QUANT,
    S_SUM,
    S_DEN,
    S_DIVW,
    S_DONE
  } state_t;

  // configuration
  logic [15:0]        clamp_limit_r;
  logic [31:0]        quant_gain_r;
  logic signed [7:0]  zero_point_r;
  logic [15:0]        score_threshold_r;

  // background table
  logic [15:0]        bg_mem [GRID*GRID];
  logic [15:0]        bg_rd_r;
  logic [ADDR_W-1:0]  bg_addr;
  logic               on_grid;
  logic               in_accept;

  // sequencer and datapath
  state_t             state_r;
  kind_t              kind_r;
  logic [15:0]        pix_r;
  logic [15:0]        score_r;
  logic [IDX_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum_r;
  logic [WSUM_W-1:0]  wsum_r;
  logic [PROD_W-1:0]  prod_r;
  logic signed [7:0]  quant_r;
  logic [15:0]        norm_r;
  logic [15:0]        cen_r;
  logic               det_r;
  logic [ENERGY_W-1:0] energy_r [GRID];
  logic               out_vld_r;
  out_item_t          out_item_r;

  logic [15:0]        lim;
  logic [15:0]        diff_raw;
  logic [15:0]        d;
  logic [16:0]        e_sum;
  logic [ENERGY_W-1:0] e_new;
  logic [DEN_W-1:0]   den_full;
  logic               det_now;
  logic [PROD_W:0]    q_round;
  logic [24:0]        q_shift;
  logic signed [25:0] q_zp;
  logic signed [7:0]  q_sat;
  logic               div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic               div_done;
  logic [DIV_NUM_W-1:0] div_quot;
  logic [15:0]        cen_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign on_grid   = (32'(in_item.row) < GRID) && (32'(in_item.col) < GRID);
  assign bg_addr   = ADDR_W'(32'(in_item.row) * GRID + 32'(in_item.col));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_limit_r     <= 16'd400;
      quant_gain_r      <= 32'd10737418;
      zero_point_r      <= -8'sd128;
      score_threshold_r <= 16'd32768;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLAMP_LIMIT:     clamp_limit_r     <= cfg_data[15:0];
        CFG_QUANT_GAIN:      quant_gain_r      <= cfg_data;
        CFG_ZERO_POINT:      zero_point_r      <= $signed(cfg_data[7:0]);
        CFG_SCORE_THRESHOLD: score_threshold_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_item.op == OP_LOAD && on_grid) begin
      bg_mem[bg_addr] <= in_item.sample;
    end
    bg_rd_r <= bg_mem[bg_addr];
  end

  // pixel datapath
  assign lim      = (clamp_limit_r == 16'd0) ? 16'd1 : clamp_limit_r;
  assign diff_raw = (bg_rd_r > pix_r) ? bg_rd_r - pix_r : 16'd0;
  assign d        = (diff_raw > lim) ? lim : diff_raw;
  assign e_sum    = 17'(energy_r[cnt_r]) + 17'(d);
  assign e_new    = (e_sum > 17'(ENERGY_MAX)) ? ENERGY_MAX : e_sum[ENERGY_W-1:0];

  // round, drop the 24 fraction bits, add the zero point, saturate to int8
  assign q_round  = (PROD_W+1)'(prod_r) + (PROD_W+1)'(1 << 23);
  assign q_shift  = q_round[48:24];
  assign q_zp     = $signed({1'b0, q_shift}) + 26'(zero_point_r);
  always_comb begin
    if (q_zp < -26'sd128) begin
      q_sat = -8'sd128;
    end else if (q_zp > 26'sd127) begin
      q_sat = 8'sd127;
    end else begin
      q_sat = q_zp[7:0];
    end
  end

  // frame datapath
  assign den_full = DEN_W'(sum_r) * DEN_W'(GRID - 1);
  assign det_now  = (score_r > score_threshold_r) && (sum_r != '0);
  assign cen_sat  = (|div_quot[DIV_NUM_W-1:16]) ? 16'hFFFF : div_quot[15:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_r == S_PIX) begin
      div_start = 1'b1;
      div_num   = (DIV_NUM_W'(d) << 15) + DIV_NUM_W'(lim >> 1);
      div_den   = DIV_DEN_W'(lim);
    end else if (state_r == S_DEN && det_now) begin
      div_start = 1'b1;
      div_num   = (DIV_NUM_W'(wsum_r) << 16) + DIV_NUM_W'(den_full >> 1);
      div_den   = DIV_DEN_W'(den_full);
    end
  end

  dfpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_vld_r   <= 1'b0;
      cnt_r       <= '0;
      for (int i = 0; i < GRID; i++) begin
        energy_r[i] <= '0;
      end
    end else begin
      // in S_DONE the output register is refilled or held below
      if (out_vld_r && !out_stall && state_r != S_DONE) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            case (in_item.op)
              OP_PIXEL: begin
                if (on_grid) begin
                  kind_r  <= KIND_PIXEL;
                  pix_r   <= in_item.sample;
                  cnt_r   <= in_item.col[IDX_W-1:0];
                  state_r <= S_PIX;
                end
              end
              OP_FINISH: begin
                kind_r  <= KIND_FRAME;
                score_r <= in_item.score;
                cnt_r   <= '0;
                sum_r   <= '0;
                wsum_r  <= '0;
                state_r <= S_SUM;
              end
              default: ;
            endcase
          end
        end
        S_PIX: begin
          energy_r[cnt_r] <= e_new;
          prod_r          <= PROD_W'(d) * PROD_W'(quant_gain_r);
          state_r         <= S_QUANT;
        end
        S_QUANT: begin
          quant_r <= q_sat;
          state_r <= S_DIVW;
        end
        S_SUM: begin
          sum_r  <= sum_r + SUM_W'(energy_r[cnt_r]);
          wsum_r <= wsum_r + WSUM_W'(energy_r[cnt_r]) * WSUM_W'(cnt_r);
          if (cnt_r == IDX_W'(GRID - 1)) begin
            state_r <= S_DEN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DEN: begin
          det_r <= det_now;
          for (int i = 0; i < GRID; i++) begin
            energy_r[i] <= '0;
          end
          if (det_now) begin
            state_r <= S_DIVW;
          end else begin
            cen_r   <= CENTROID_DEFAULT;
            state_r <= S_DONE;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            if (kind_r == KIND_PIXEL) begin
              norm_r <= div_quot[15:0];
            end else begin
              cen_r <= cen_sat;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // wait for the output register to be free
          if (!out_vld_r || !out_stall) begin
            out_vld_r       <= 1'b1;
            out_item_r.kind <= kind_r;
            if (kind_r == KIND_PIXEL) begin
              out_item_r.norm      <= norm_r;
              out_item_r.quantized <= quant_r;
              out_item_r.centroid  <= 16'd0;
              out_item_r.detected  <= 1'b0;
            end else begin
              out_item_r.norm      <= 16'd0;
              out_item_r.quantized <= 8'sd0;
              out_item_r.centroid  <= cen_r;
              out_item_r.detected  <= det_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_item_r;

endmodule

`default_nettype wire
